>>> sv/ccov_pkg.sv
package ccov_pkg;

    // Fixed geometry of the cursor and the screen format
    localparam int SCALE           = 2;
    localparam int CURSOR_ROWS     = 32;
    localparam int WORD_BITS       = 32;
    localparam int RECT_WIDTH      = 64;
    localparam int PIXELS_PER_BYTE = 8;

    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    // Input item kinds (carried on tuser)
    localparam logic OP_POSITION = 1'b0;
    localparam logic OP_ROW      = 1'b1;

    // Register map indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCREEN_LEFT   = 3'd0;
    localparam logic [2:0] REG_SCREEN_TOP    = 3'd1;
    localparam logic [2:0] REG_SCREEN_RIGHT  = 3'd2;
    localparam logic [2:0] REG_SCREEN_BOTTOM = 3'd3;
    localparam logic [2:0] REG_HOTSPOT_X     = 3'd4;
    localparam logic [2:0] REG_HOTSPOT_Y     = 3'd5;
    localparam logic [2:0] REG_ROW_BYTES     = 3'd6;

    // Which screen edge clipped the rectangle
    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_LEFT  = 2'd1,
        EDGE_RIGHT = 2'd2
    } t_edge;

    typedef struct packed {
        logic [11:0] screen_left;
        logic [11:0] screen_top;
        logic [11:0] screen_right;
        logic [11:0] screen_bottom;
        logic [5:0]  hotspot_x;
        logic [5:0]  hotspot_y;
        logic [12:0] row_bytes;
    } t_cfg;

    // State left behind by a position item for the row items after it
    typedef struct packed {
        logic [4:0] bit_offset;
        t_edge      edge_side;
    } t_curs_state;

    typedef struct packed {
        logic [31:0]        new_word_left;
        logic [31:0]        new_word_right;
        logic [11:0]        rect_top;
        logic [11:0]        rect_left;
        logic signed [13:0] rect_bottom;
        logic [12:0]        rect_right;
        logic [5:0]         first_row;
        logic [5:0]         row_count;
        logic [23:0]        start_offset;
    } t_result;

endpackage

>>> sv/ccov_cfg_regs.sv
module ccov_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output ccov_pkg::t_cfg o_cfg
);

    ccov_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register write, values masked to their field widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_left   <= 12'd0;
            r_cfg.screen_top    <= 12'd0;
            r_cfg.screen_right  <= 12'd1024;
            r_cfg.screen_bottom <= 12'd684;
            r_cfg.hotspot_x     <= 6'd0;
            r_cfg.hotspot_y     <= 6'd0;
            r_cfg.row_bytes     <= 13'd128;
        end else if (wr_en) begin
            unique case (reg_idx)
                ccov_pkg::REG_SCREEN_LEFT:   r_cfg.screen_left   <= pwdata[11:0];
                ccov_pkg::REG_SCREEN_TOP:    r_cfg.screen_top    <= pwdata[11:0];
                ccov_pkg::REG_SCREEN_RIGHT:  r_cfg.screen_right  <= pwdata[11:0];
                ccov_pkg::REG_SCREEN_BOTTOM: r_cfg.screen_bottom <= pwdata[11:0];
                ccov_pkg::REG_HOTSPOT_X:     r_cfg.hotspot_x     <= pwdata[5:0];
                ccov_pkg::REG_HOTSPOT_Y:     r_cfg.hotspot_y     <= pwdata[5:0];
                ccov_pkg::REG_ROW_BYTES:     r_cfg.row_bytes     <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            ccov_pkg::REG_SCREEN_LEFT:   prdata = {20'd0, r_cfg.screen_left};
            ccov_pkg::REG_SCREEN_TOP:    prdata = {20'd0, r_cfg.screen_top};
            ccov_pkg::REG_SCREEN_RIGHT:  prdata = {20'd0, r_cfg.screen_right};
            ccov_pkg::REG_SCREEN_BOTTOM: prdata = {20'd0, r_cfg.screen_bottom};
            ccov_pkg::REG_HOTSPOT_X:     prdata = {26'd0, r_cfg.hotspot_x};
            ccov_pkg::REG_HOTSPOT_Y:     prdata = {26'd0, r_cfg.hotspot_y};
            ccov_pkg::REG_ROW_BYTES:     prdata = {19'd0, r_cfg.row_bytes};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/ccov_pos_calc.sv
module ccov_pos_calc (
    input  ccov_pkg::t_cfg        i_cfg,
    input  logic [10:0]           i_mouse_x,
    input  logic [10:0]           i_mouse_y,
    output ccov_pkg::t_result     o_res,
    output ccov_pkg::t_curs_state o_state
);

    logic signed [13:0] left_raw, left_al, left_l, left_c, left_cap;
    logic signed [13:0] top_raw, top_c, skip_full, height_t, height, lim;
    logic signed [13:0] scr_left, scr_top, scr_bot;
    logic signed [13:0] left_q;
    logic               lclip, rclip, tclip;
    logic [24:0]        prod;
    logic [25:0]        offset;

    always_comb begin
        scr_left = $signed(14'(i_cfg.screen_left));
        scr_top  = $signed(14'(i_cfg.screen_top));
        scr_bot  = $signed(14'(i_cfg.screen_bottom));

        // Scale, remove hotspot, align down to a word
        left_raw = $signed(14'(i_mouse_x)) * 14'(ccov_pkg::SCALE)
                   - $signed(14'(i_cfg.hotspot_x));
        top_raw  = $signed(14'(i_mouse_y)) * 14'(ccov_pkg::SCALE)
                   - $signed(14'(i_cfg.hotspot_y));
        left_al  = {left_raw[13:5], 5'd0};

        // Horizontal clamp: left edge first, then right edge
        lclip    = left_al < scr_left;
        left_l   = lclip ? scr_left : left_al;
        left_cap = $signed(14'(i_cfg.screen_right)) - 14'(ccov_pkg::RECT_WIDTH);
        rclip    = left_l > left_cap;
        left_c   = rclip ? left_cap : left_l;

        // Top clip skips cursor rows
        tclip     = top_raw < scr_top;
        skip_full = scr_top - top_raw;
        height_t  = tclip ? 14'(ccov_pkg::CURSOR_ROWS) - skip_full
                          : 14'(ccov_pkg::CURSOR_ROWS);
        top_c     = tclip ? scr_top : top_raw;

        // Bottom clip shortens the row count
        lim    = scr_bot - top_c;
        height = ((top_c + 14'(ccov_pkg::CURSOR_ROWS) > scr_bot) && (lim < height_t))
                 ? lim : height_t;

        // Byte offset; left / 8 rounds toward zero
        left_q = left_c >>> 3;
        if (left_c[13] && (left_c[2:0] != 3'd0)) begin
            left_q = left_q + 14'sd1;
        end
        prod   = 25'(top_c[11:0]) * 25'(i_cfg.row_bytes);
        offset = {1'b0, prod} + {{12{left_q[13]}}, left_q};

        o_res              = '0;
        o_res.rect_top     = top_c[11:0];
        o_res.rect_left    = left_c[11:0];
        o_res.rect_bottom  = top_c + height;
        o_res.rect_right   = 13'(left_c + 14'(ccov_pkg::RECT_WIDTH));
        o_res.first_row    = !tclip ? 6'd0
                           : (skip_full > 14'(ccov_pkg::CURSOR_ROWS))
                             ? 6'(ccov_pkg::CURSOR_ROWS) : skip_full[5:0];
        o_res.row_count    = (height > 14'sd0) ? height[5:0] : 6'd0;
        o_res.start_offset = offset[23:0];

        o_state.bit_offset = left_raw[4:0];
        if (lclip && !rclip) begin
            o_state.edge_side = ccov_pkg::EDGE_LEFT;
        end else if (rclip && !lclip) begin
            o_state.edge_side = ccov_pkg::EDGE_RIGHT;
        end else begin
            o_state.edge_side = ccov_pkg::EDGE_NONE;
        end
    end

endmodule

>>> sv/ccov_row_comp.sv
module ccov_row_comp (
    input  ccov_pkg::t_curs_state i_state,
    input  logic [31:0]           i_screen_word_left,
    input  logic [31:0]           i_screen_word_right,
    input  logic [31:0]           i_cursor_data_word,
    input  logic [31:0]           i_cursor_mask_word,
    output ccov_pkg::t_result     o_res
);

    logic [63:0] data_dbl, mask_dbl;
    logic [31:0] data_rot, mask_rot, lm, rm, lm_e, rm_e;

    always_comb begin
        // Rotate right by the kept bit offset
        data_dbl = {i_cursor_data_word, i_cursor_data_word} >> i_state.bit_offset;
        mask_dbl = {i_cursor_mask_word, i_cursor_mask_word} >> i_state.bit_offset;
        data_rot = data_dbl[31:0];
        mask_rot = mask_dbl[31:0];

        // Edge masks split the rotated word over left and right screen words
        lm = ccov_pkg::FULL_WORD >> i_state.bit_offset;
        rm = ~lm;
        case (i_state.edge_side)
            ccov_pkg::EDGE_LEFT: begin
                lm_e = rm;
                rm_e = 32'd0;
            end
            ccov_pkg::EDGE_RIGHT: begin
                lm_e = 32'd0;
                rm_e = lm;
            end
            default: begin
                lm_e = lm;
                rm_e = rm;
            end
        endcase

        o_res                = '0;
        o_res.new_word_left  = (i_screen_word_left & ~(mask_rot & lm_e)) ^ (data_rot & lm_e);
        o_res.new_word_right = (i_screen_word_right & ~(mask_rot & rm_e)) ^ (data_rot & rm_e);
    end

endmodule

>>> sv/cursor_clip_and_overlay_core.sv
// Channel   | Dir | Handshake              | Payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: items, tuser: kind (0 pos, 1 row)
// m_axis    | out | m_axis_tvalid/tready   | tdata: one result per input item
// APB       | in  | psel/penable, pready=1 | 7 registers at 4*index, 32-bit data
//
// Every item passes through the input register, then through the compute
// logic into the result register.
// One item is accepted per cycle unless m_axis stalls; throughput is set by the single
// input/result register pair. A stalled m_axis holds the result register and
// backs up into the input register, then drops s_axis_tready.
// Synchronous active-low reset empties both registers and restores the
// register reset values; the block takes items in the first cycle after it.
module cursor_clip_and_overlay_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: mouse_x[10:0], mouse_y[21:11], screen_word_left[53:22],
    //        screen_word_right[85:54], cursor_data_word[117:86],
    //        cursor_mask_word[149:118], zero pad[151:150]
    input  logic [151:0]  s_axis_tdata,
    // tuser: opcode[0]
    input  logic          s_axis_tuser,
    // Output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: new_word_left[31:0], new_word_right[63:32], rect_top[75:64],
    //        rect_left[87:76], rect_bottom[101:88], rect_right[114:102],
    //        first_row[120:115], row_count[126:121], start_offset[150:127],
    //        zero pad[151]
    output logic [151:0]  m_axis_tdata
);

    ccov_pkg::t_cfg        cfg;
    ccov_pkg::t_curs_state r_state, pos_state;
    ccov_pkg::t_result     pos_res, row_res, n_res, r_res;

    logic         r_in_vld, r_out_vld, advance;
    logic         r_in_op;
    logic [149:0] r_in_data;

    assign pready = 1'b1;

    ccov_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // Pipeline control: input register moves on when the result register frees
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata[149:0];
        end
    end

    ccov_pos_calc u_pos (
        .i_cfg     (cfg),
        .i_mouse_x (r_in_data[10:0]),
        .i_mouse_y (r_in_data[21:11]),
        .o_res     (pos_res),
        .o_state   (pos_state)
    );

    ccov_row_comp u_row (
        .i_state             (r_state),
        .i_screen_word_left  (r_in_data[53:22]),
        .i_screen_word_right (r_in_data[85:54]),
        .i_cursor_data_word  (r_in_data[117:86]),
        .i_cursor_mask_word  (r_in_data[149:118]),
        .o_res               (row_res)
    );

    assign n_res = (r_in_op == ccov_pkg::OP_ROW) ? row_res : pos_res;

    // Cursor state, updated as a position item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.bit_offset <= 5'd0;
            r_state.edge_side  <= ccov_pkg::EDGE_NONE;
        end else if (advance && (r_in_op == ccov_pkg::OP_POSITION)) begin
            r_state <= pos_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tdata = {1'b0,
                           r_res.start_offset,
                           r_res.row_count,
                           r_res.first_row,
                           r_res.rect_right,
                           r_res.rect_bottom,
                           r_res.rect_left,
                           r_res.rect_top,
                           r_res.new_word_right,
                           r_res.new_word_left};

    // A full pipeline with a stalled output must stop taking input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    // An accepted transaction lands in the input register
    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_vld)
        else $error("accepted transaction lost from input register");

    // Row transactions never disturb the cursor state
    a_row_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_op == ccov_pkg::OP_ROW) |=> $stable(r_state))
        else $error("cursor state changed by a row transaction");

    // Row count never exceeds the cursor height
    a_row_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_res.row_count <= 6'(ccov_pkg::CURSOR_ROWS))
        else $error("row count beyond cursor height");

    // An advancing transaction always produces a valid result next cycle
    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("result register not loaded");

endmodule

>>> bench/cursor_clip_and_overlay_core_test.sv
`timescale 1ns / 100ps

module cursor_clip_and_overlay_core_test;

    localparam int RESET_CYCLES   = 11;
    localparam int MAX_WAIT       = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 6;
    // Quiet cycles allowed: the long receiver hold plus worst gaps, taken several times over
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 115;
    // Address past the end of the register map; a write there must change nothing
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic        opcode;
        logic [10:0] mouse_x;
        logic [10:0] mouse_y;
        logic [31:0] screen_word_left;
        logic [31:0] screen_word_right;
        logic [31:0] cursor_data_word;
        logic [31:0] cursor_mask_word;
    } t_cursor_item;

    logic          i_clk;
    logic          i_rst_n       = 1'b0;
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [4:0]    paddr         = '0;
    logic [31:0]   pwdata        = '0;
    wire  [31:0]   prdata;
    wire           pready;
    logic          s_axis_tvalid = 1'b0;
    wire           s_axis_tready;
    logic [151:0]  s_axis_tdata  = '0;
    logic          s_axis_tuser  = 1'b0;
    wire           m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    wire  [151:0]  m_axis_tdata;

    cursor_clip_and_overlay_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow of the register file and of the state a position leaves for its rows
    ccov_pkg::t_cfg    shadow_cfg;
    logic [4:0]        shadow_bit_offset;
    ccov_pkg::t_edge   shadow_edge;

    t_cursor_item       queued_items[$];
    ccov_pkg::t_result  expected_overlays[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  send_wait      = 0;
    int  recv_wait      = 0;
    int  quiet_cycles   = 0;
    int  hold_count     = 0;
    bit  send_idle      = 1'b0;
    bit  recv_idle      = 1'b0;
    logic stall_req     = 1'b0;
    logic hold_active   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit idle_on);
        if (idle_on && $urandom_range(0, 2) != 0) begin
            return $urandom_range(0, MAX_WAIT);
        end
        return 0;
    endfunction

    function automatic logic [31:0] rotate_right(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] both;
        both = {v, v} >> n;
        return both[31:0];
    endfunction

    // Expected result of one transaction; position items also update the shadow state
    task automatic predict_overlay(input t_cursor_item it, output ccov_pkg::t_result r);
        longint left, top, height, skip, left_cap, offset, bottom, right;
        int side;
        logic [4:0]  offs;
        logic [31:0] d, m, lm, rm;
        r = '0;
        if (it.opcode == ccov_pkg::OP_POSITION) begin
            left   = ccov_pkg::SCALE * longint'(it.mouse_x)
                     - longint'(shadow_cfg.hotspot_x);
            top    = ccov_pkg::SCALE * longint'(it.mouse_y)
                     - longint'(shadow_cfg.hotspot_y);
            height = ccov_pkg::CURSOR_ROWS;
            skip   = 0;
            side   = 0;
            offs   = left[4:0];
            left   = left - longint'(offs);
            // horizontal clamp, both clips may cancel
            if (left < longint'(shadow_cfg.screen_left)) begin
                side--;
                left = longint'(shadow_cfg.screen_left);
            end
            left_cap = longint'(shadow_cfg.screen_right) - ccov_pkg::RECT_WIDTH;
            if (left > left_cap) begin
                side++;
                left = left_cap;
            end
            // top clip skips cursor rows, bottom clip shortens the count
            if (top < longint'(shadow_cfg.screen_top)) begin
                skip   = longint'(shadow_cfg.screen_top) - top;
                height = height - skip;
                top    = longint'(shadow_cfg.screen_top);
                if (skip > ccov_pkg::CURSOR_ROWS) begin
                    skip = ccov_pkg::CURSOR_ROWS;
                end
            end
            if (top + ccov_pkg::CURSOR_ROWS > longint'(shadow_cfg.screen_bottom)) begin
                if (longint'(shadow_cfg.screen_bottom) - top < height) begin
                    height = longint'(shadow_cfg.screen_bottom) - top;
                end
            end
            shadow_bit_offset = offs;
            shadow_edge = (side < 0) ? ccov_pkg::EDGE_LEFT
                        : ((side > 0) ? ccov_pkg::EDGE_RIGHT : ccov_pkg::EDGE_NONE);

            offset = top * longint'(shadow_cfg.row_bytes) + left / ccov_pkg::PIXELS_PER_BYTE;
            bottom = top + height;
            right  = left + ccov_pkg::RECT_WIDTH;
            r.rect_top     = top[11:0];
            r.rect_left    = left[11:0];
            r.rect_bottom  = bottom[13:0];
            r.rect_right   = right[12:0];
            r.first_row    = skip[5:0];
            r.row_count    = (height > 0) ? height[5:0] : 6'd0;
            r.start_offset = offset[23:0];
        end else begin
            d  = rotate_right(it.cursor_data_word, shadow_bit_offset);
            m  = rotate_right(it.cursor_mask_word, shadow_bit_offset);
            lm = ccov_pkg::FULL_WORD >> shadow_bit_offset;
            rm = ~lm;
            case (shadow_edge)
                ccov_pkg::EDGE_LEFT: begin
                    lm = rm;
                    rm = '0;
                end
                ccov_pkg::EDGE_RIGHT: begin
                    rm = lm;
                    lm = '0;
                end
                default: ;
            endcase
            r.new_word_left  = (it.screen_word_left & ~(m & lm)) ^ (d & lm);
            r.new_word_right = (it.screen_word_right & ~(m & rm)) ^ (d & rm);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_result();
        ccov_pkg::t_result want;
        if (expected_overlays.size() == 0) begin
            report_mismatch("result with no transaction waiting for it");
        end else begin
            want = expected_overlays.pop_front();
            check_field("new_word_left", m_axis_tdata[31:0], want.new_word_left);
            check_field("new_word_right", m_axis_tdata[63:32], want.new_word_right);
            check_field("rect_top", m_axis_tdata[75:64], want.rect_top);
            check_field("rect_left", m_axis_tdata[87:76], want.rect_left);
            check_field("rect_bottom", longint'($signed(m_axis_tdata[101:88])),
                        longint'(want.rect_bottom));
            check_field("rect_right", m_axis_tdata[114:102], want.rect_right);
            check_field("first_row", m_axis_tdata[120:115], want.first_row);
            check_field("row_count", m_axis_tdata[126:121], want.row_count);
            check_field("start_offset", m_axis_tdata[150:127], want.start_offset);
        end
        results_seen++;
    endtask

    // Input driver: one queued transaction at a time, random gap after each
    always @(posedge i_clk) begin : stream_driver
        t_cursor_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait     <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // block is full, keep offering the same transaction
        end else if (send_wait != 0) begin
            s_axis_tvalid <= 1'b0;
            send_wait     <= send_wait - 1;
        end else if (queued_items.size() != 0) begin
            it = queued_items.pop_front();
            s_axis_tdata  <= {2'b00, it.cursor_mask_word, it.cursor_data_word,
                              it.screen_word_right, it.screen_word_left,
                              it.mouse_y, it.mouse_x};
            s_axis_tuser  <= it.opcode;
            s_axis_tvalid <= 1'b1;
            send_wait     <= draw_wait(send_idle);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Accepted inputs feed the predictor
    always @(posedge i_clk) begin : input_monitor
        t_cursor_item      it;
        ccov_pkg::t_result r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.opcode            = s_axis_tuser;
            it.mouse_x           = s_axis_tdata[10:0];
            it.mouse_y           = s_axis_tdata[21:11];
            it.screen_word_left  = s_axis_tdata[53:22];
            it.screen_word_right = s_axis_tdata[85:54];
            it.cursor_data_word  = s_axis_tdata[117:86];
            it.cursor_mask_word  = s_axis_tdata[149:118];
            predict_overlay(it, r);
            expected_overlays.push_back(r);
        end
    end

    // Long receiver hold-off, counted here once requested
    always @(posedge i_clk) begin
        if (stall_req && hold_count < HOLD_CYCLES) begin
            hold_active <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            hold_active <= 1'b0;
        end
    end

    // Output receiver: checks each result and draws a stall after it
    always @(posedge i_clk) begin : result_monitor
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (hold_active) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                w = draw_wait(recv_idle);
                recv_wait     <= w;
                m_axis_tready <= (w == 0);
            end else if (recv_wait != 0) begin
                recv_wait     <= recv_wait - 1;
                m_axis_tready <= (recv_wait == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("cursor_clip_and_overlay_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // APB write: setup cycle, access cycle; upper bits sometimes carry junk
    task automatic write_reg(input logic [2:0] idx, input int unsigned val, input int width);
        logic [31:0] value;
        value = val;
        if ($urandom_range(0, 3) == 0 && width < 32) begin
            value = value | ($urandom() << width);
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ccov_pkg::REG_SCREEN_LEFT:   shadow_cfg.screen_left   = value[11:0];
            ccov_pkg::REG_SCREEN_TOP:    shadow_cfg.screen_top    = value[11:0];
            ccov_pkg::REG_SCREEN_RIGHT:  shadow_cfg.screen_right  = value[11:0];
            ccov_pkg::REG_SCREEN_BOTTOM: shadow_cfg.screen_bottom = value[11:0];
            ccov_pkg::REG_HOTSPOT_X:     shadow_cfg.hotspot_x     = value[5:0];
            ccov_pkg::REG_HOTSPOT_Y:     shadow_cfg.hotspot_y     = value[5:0];
            ccov_pkg::REG_ROW_BYTES:     shadow_cfg.row_bytes     = value[12:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int sl, input int st, input int sr, input int sb,
                                input int hx, input int hy, input int rb);
        write_reg(ccov_pkg::REG_SCREEN_LEFT, sl, 12);
        write_reg(ccov_pkg::REG_SCREEN_TOP, st, 12);
        write_reg(ccov_pkg::REG_SCREEN_RIGHT, sr, 12);
        write_reg(ccov_pkg::REG_SCREEN_BOTTOM, sb, 12);
        write_reg(ccov_pkg::REG_HOTSPOT_X, hx, 6);
        write_reg(ccov_pkg::REG_HOTSPOT_Y, hy, 6);
        write_reg(ccov_pkg::REG_ROW_BYTES, rb, 13);
    endtask

    task automatic random_config(input int kind);
        int sl, st;
        case (kind)
            0: apply_config(0, 0, 0, 0, 0, 0, 1);
            1: apply_config(4095, 4095, 4095, 4095, 63, 63, 4096);
            2: apply_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(1, 4096));
            default: begin
                sl = $urandom_range(0, 512);
                st = $urandom_range(0, 400);
                apply_config(sl, st, sl + $urandom_range(64, 3000), st + $urandom_range(0, 3000),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(1, 4096));
            end
        endcase
    endtask

    // Wait until the block has drained, then let its pipeline settle
    task automatic wait_idle();
        while (queued_items.size() != 0 || s_axis_tvalid || expected_overlays.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ccov_pkg::FULL_WORD;
            default: return $urandom();
        endcase
    endfunction

    // Mouse coordinate that puts the scaled point near a given screen pixel
    function automatic logic [10:0] aim(input int pixel, input int hot);
        int v;
        v = (pixel + hot + int'($urandom_range(0, 80)) - 40) / ccov_pkg::SCALE;
        if (v < 0) begin
            v = 0;
        end
        if (v > 2047) begin
            v = 2047;
        end
        return v[10:0];
    endfunction

    task automatic push_position(input logic [10:0] mx, input logic [10:0] my);
        t_cursor_item it;
        it.opcode            = ccov_pkg::OP_POSITION;
        it.mouse_x           = mx;
        it.mouse_y           = my;
        it.screen_word_left  = $urandom();
        it.screen_word_right = $urandom();
        it.cursor_data_word  = $urandom();
        it.cursor_mask_word  = $urandom();
        queued_items.push_back(it);
    endtask

    task automatic push_row(input logic [31:0] sl, input logic [31:0] sr,
                            input logic [31:0] d, input logic [31:0] m);
        t_cursor_item it;
        it.opcode            = ccov_pkg::OP_ROW;
        it.mouse_x           = 11'($urandom());
        it.mouse_y           = 11'($urandom());
        it.screen_word_left  = sl;
        it.screen_word_right = sr;
        it.cursor_data_word  = d;
        it.cursor_mask_word  = m;
        queued_items.push_back(it);
    endtask

    task automatic push_random_position();
        int hx, hy;
        hx = int'(shadow_cfg.hotspot_x);
        hy = int'(shadow_cfg.hotspot_y);
        case ($urandom_range(0, 3))
            0: push_position(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
            1: push_position(aim(int'(shadow_cfg.screen_left), hx),
                             aim(int'(shadow_cfg.screen_top), hy));
            2: push_position(aim(int'(shadow_cfg.screen_right) - ccov_pkg::RECT_WIDTH, hx),
                             aim(int'(shadow_cfg.screen_bottom) - ccov_pkg::CURSOR_ROWS, hy));
            default: push_position(
                aim(int'($urandom_range(shadow_cfg.screen_left, shadow_cfg.screen_right)), hx),
                aim(int'($urandom_range(shadow_cfg.screen_top, shadow_cfg.screen_bottom)), hy));
        endcase
    endtask

    initial begin : main
        int n, rows, p;
        shadow_cfg.screen_left   = 12'd0;
        shadow_cfg.screen_top    = 12'd0;
        shadow_cfg.screen_right  = 12'd1024;
        shadow_cfg.screen_bottom = 12'd684;
        shadow_cfg.hotspot_x     = 6'd0;
        shadow_cfg.hotspot_y     = 6'd0;
        shadow_cfg.row_bytes     = 13'd128;
        shadow_bit_offset        = '0;
        shadow_edge              = ccov_pkg::EDGE_NONE;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, right clip with a large offset, plain rows
        @(negedge i_clk);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        push_position(11'd0, 11'd0);
        push_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_position(11'd2047, 11'd2047);
        push_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 32'hFF00_FF00);
        push_position(11'd250, 11'd100);
        push_row(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'h0);
        push_row(32'h0, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hFFFF_FFFF);
        push_position(11'd0, 11'd2047);
        push_position(11'd2047, 11'd0);
        push_row(rand_word(), rand_word(), rand_word(), rand_word());
        wait_idle();

        // Left clip with zero offset, top clip, right clip, bottom clip
        apply_config(64, 40, 960, 600, 0, 0, 4096);
        @(negedge i_clk);
        push_position(11'd0, 11'd0);
        push_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_position(11'd10, 11'd15);
        push_row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_position(11'd600, 11'd100);
        push_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        push_position(11'd100, 11'd295);
        wait_idle();

        // Narrow screen: both edge clips cancel; skipped rows held at the cursor height
        apply_config(200, 0, 230, 4095, 63, 63, 1);
        write_reg(REG_UNMAPPED, $urandom(), 32);
        @(negedge i_clk);
        push_position(11'd0, 11'd0);
        push_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_position(11'd2047, 11'd2047);
        push_row(rand_word(), rand_word(), rand_word(), rand_word());
        wait_idle();

        // Screen narrower than the rectangle: left goes negative
        apply_config(0, 4095, 10, 0, 63, 0, 4096);
        @(negedge i_clk);
        push_position(11'd5, 11'd2047);
        push_row(rand_word(), rand_word(), rand_word(), rand_word());
        wait_idle();

        // Random phases: mostly a position followed by its rows, some noise
        for (p = 0; p < RANDOM_PHASES; p++) begin
            random_config((p < 2) ? p : ((p % 4 == 2) ? 2 : 3));
            if (p % 5 == 4) begin
                write_reg(REG_UNMAPPED, $urandom(), 32);
            end
            @(negedge i_clk);
            send_idle = (p % 3 != 1);
            recv_idle = (p % 3 != 2);
            if (p == 1) begin
                stall_req <= 1'b1;
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0: begin
                        push_row(rand_word(), rand_word(), rand_word(), rand_word());
                        n++;
                    end
                    1: begin
                        push_random_position();
                        n++;
                    end
                    default: begin
                        push_random_position();
                        rows = ($urandom_range(0, 3) == 0)
                               ? $urandom_range(0, ccov_pkg::CURSOR_ROWS)
                               : $urandom_range(1, 12);
                        repeat (rows) push_row(rand_word(), rand_word(), rand_word(),
                                               rand_word());
                        n += rows + 1;
                    end
                endcase
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("cursor_clip_and_overlay_core test passed");
        end else begin
            $display("cursor_clip_and_overlay_core test failed");
        end
        $finish;
    end

endmodule
